[rtl/core/scan_merge_best_signal_table_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the scan table block
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SCAN_MERGE_BEST_SIGNAL_TABLE_DEFINES_SVH
`define SCAN_MERGE_BEST_SIGNAL_TABLE_DEFINES_SVH

// same-cycle implication
`define SMBST_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("smbst same-cycle check failed");

// next-cycle implication
`define SMBST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("smbst next-cycle check failed");

`endif

[rtl/core/smbst_pkg.sv]
// ----------------------------------------------------------------------------
// smbst_pkg
// Types and codes shared by the scan table modules.
// ----------------------------------------------------------------------------
package smbst_pkg;

   localparam int ADDR_W = 48;
   localparam int STR_W  = 8;
   localparam int CHAN_W = 8;

   // command codes
   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_FINISH = 2'd2;

   typedef struct packed {
      logic [ADDR_W-1:0]       addr;
      logic signed [STR_W-1:0] strength;
      logic [CHAN_W-1:0]       channel;
      logic                    match;
   } entry_type;

   // compare unit result: a vs b
   typedef struct packed {
      logic addr_eq;
      logic str_gt;
      logic str_eq;
   } cmp_res_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_INS  = 3'b010,
      ST_SORT = 3'b100
   } state_type;

endpackage

[rtl/core/smbst_cmp.sv]
// ----------------------------------------------------------------------------
// smbst_cmp
// Shared compare unit: address equality and signed strength order.
// ----------------------------------------------------------------------------
module smbst_cmp import smbst_pkg::*; (
   input  logic [ADDR_W-1:0]       addr_a,
   input  logic [ADDR_W-1:0]       addr_b,
   input  logic signed [STR_W-1:0] str_a,
   input  logic signed [STR_W-1:0] str_b,
   output cmp_res_type             res
);

   always_comb begin
      res.addr_eq = (addr_a == addr_b);
      res.str_gt  = (str_a > str_b);
      res.str_eq  = (str_a == str_b);
   end

endmodule

[rtl/core/smbst_entry_ram.sv]
// ----------------------------------------------------------------------------
// smbst_entry_ram
// Entry store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module smbst_entry_ram import smbst_pkg::*; #(
   parameter int DEPTH = 32,
   parameter int IDX_W = 5
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/scan_merge_best_signal_table.sv]
// ----------------------------------------------------------------------------
// scan_merge_best_signal_table: best-signal scan table, one compare unit
// Clear: resets the entry count. Insert: scans the N stored entries, ending early
//   on an address match, through the single read port, one entry per cycle.
// Finish: (D+1) scans of the entries, D = distinct strengths; results strobe
//   during the scans, no stall possible. Empty table: one result next cycle.
// One item at a time: the next one is taken in the cycle busy drops.
// Reset clears the entry count and control only; entries need no clearing.
// ----------------------------------------------------------------------------
module scan_merge_best_signal_table import smbst_pkg::*; #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_command,
   input  logic [ADDR_W-1:0]       req_station_address,
   input  logic signed [STR_W-1:0] req_signal_strength,
   input  logic [CHAN_W-1:0]       req_radio_channel,
   input  logic                    req_name_matches,
   output logic                    rsp_strobe,
   output logic                    rsp_entry_valid,
   output logic [ADDR_W-1:0]       rsp_out_address,
   output logic signed [STR_W-1:0] rsp_out_strength,
   output logic [CHAN_W-1:0]       rsp_out_channel,
   output logic                    rsp_out_name_matches,
   output logic                    rsp_last_entry
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // sequencer state
   state_type             state_ff, state_in;
   entry_type             req_ff, req_in;        // latched item
   logic [CNT_W-1:0]      count_ff, count_in;    // valid entries
   logic [CNT_W-1:0]      issue_ff, issue_in;    // next read address
   logic                  chk_vld_ff, chk_vld_in; // read data in flight
   logic [IDX_W-1:0]      chk_idx_ff, chk_idx_in;
   logic [CNT_W-1:0]      emit_ff, emit_in;      // results sent this run

   // sort pass: level being emitted, best strength found below it
   logic signed [STR_W-1:0] lvl_ff, lvl_in;
   logic                    lvl_vld_ff, lvl_vld_in;
   logic signed [STR_W-1:0] nxt_ff, nxt_in;
   logic                    nxt_vld_ff, nxt_vld_in;

   // output stage
   logic      rsp_strobe_ff, rsp_strobe_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_last_ff, rsp_last_in;
   entry_type rsp_entry_ff, rsp_entry_in;

   // memory and compare unit hookup
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        rd_data;
   cmp_res_type      cmp_res;
   logic signed [STR_W-1:0] cmp_str_a;

   logic scan_done;
   logic issue_go;

   smbst_entry_ram #(
      .DEPTH (TABLE_DEPTH),
      .IDX_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_ff),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // insert: new strength vs stored; sort: level vs stored
   assign cmp_str_a = (state_ff == ST_SORT) ? lvl_ff : req_ff.strength;

   smbst_cmp u_cmp (
      .addr_a (req_ff.addr),
      .addr_b (rd_data.addr),
      .str_a  (cmp_str_a),
      .str_b  (rd_data.strength),
      .res    (cmp_res)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign issue_go  = (issue_ff < count_ff);
   assign scan_done = !chk_vld_ff && (issue_ff == count_ff);

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      emit_in       = emit_ff;
      lvl_in        = lvl_ff;
      lvl_vld_in    = lvl_vld_ff;
      nxt_in        = nxt_ff;
      nxt_vld_in    = nxt_vld_ff;
      rsp_strobe_in = 1'b0;
      rsp_last_in   = 1'b0;
      rsp_valid_in  = rsp_valid_ff;
      rsp_entry_in  = rsp_entry_ff;
      wr_en         = 1'b0;
      wr_addr       = chk_idx_ff;

      // scan front end shared by insert and sort: one read per cycle
      if (state_ff != ST_IDLE && issue_go) begin
         chk_vld_in = 1'b1;
         chk_idx_in = issue_ff[IDX_W-1:0];
         issue_in   = issue_ff + CNT_W'(1);
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_command)
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
                  CMD_INSERT: begin
                     req_in.addr     = req_station_address;
                     req_in.strength = req_signal_strength;
                     req_in.channel  = req_radio_channel;
                     req_in.match    = req_name_matches;
                     issue_in        = '0;
                     state_in        = ST_INS;
                  end
                  CMD_FINISH: begin
                     if (count_ff == '0) begin
                        // empty table: one invalid result, all fields zero
                        rsp_strobe_in = 1'b1;
                        rsp_valid_in  = 1'b0;
                        rsp_last_in   = 1'b1;
                        rsp_entry_in  = '0;
                     end else begin
                        issue_in   = '0;
                        emit_in    = '0;
                        lvl_vld_in = 1'b0;
                        nxt_vld_in = 1'b0;
                        state_in   = ST_SORT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_INS: begin
            if (chk_vld_ff && cmp_res.addr_eq) begin
               // known address: replace only when strictly stronger
               if (cmp_res.str_gt) begin
                  wr_en   = 1'b1;
                  wr_addr = chk_idx_ff;
               end
               state_in = ST_IDLE;
            end else if (scan_done) begin
               // new address: append if room, else drop
               if (count_ff < CNT_W'(TABLE_DEPTH)) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[IDX_W-1:0];
                  count_in = count_ff + CNT_W'(1);
               end
               state_in = ST_IDLE;
            end
         end

         ST_SORT: begin
            if (chk_vld_ff) begin
               // entries at the current level go out in index order
               if (lvl_vld_ff && cmp_res.str_eq) begin
                  rsp_strobe_in = 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_entry_in  = rd_data;
                  rsp_last_in   = ((emit_ff + CNT_W'(1)) == count_ff);
                  emit_in       = emit_ff + CNT_W'(1);
               end
               // track strongest value below the level (first pass: overall max)
               if ((!lvl_vld_ff || cmp_res.str_gt) &&
                   (!nxt_vld_ff || (rd_data.strength > nxt_ff))) begin
                  nxt_in     = rd_data.strength;
                  nxt_vld_in = 1'b1;
               end
            end else if (scan_done) begin
               if (emit_ff == count_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  lvl_in     = nxt_ff;
                  lvl_vld_in = 1'b1;
                  nxt_vld_in = 1'b0;
                  issue_in   = '0;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         issue_ff      <= '0;
         chk_vld_ff    <= 1'b0;
         emit_ff       <= '0;
         lvl_vld_ff    <= 1'b0;
         nxt_vld_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         rsp_last_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         issue_ff      <= issue_in;
         chk_vld_ff    <= chk_vld_in;
         emit_ff       <= emit_in;
         lvl_vld_ff    <= lvl_vld_in;
         nxt_vld_ff    <= nxt_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      chk_idx_ff   <= chk_idx_in;
      lvl_ff       <= lvl_in;
      nxt_ff       <= nxt_in;
      rsp_valid_ff <= rsp_valid_in;
      rsp_entry_ff <= rsp_entry_in;
   end

   assign rsp_strobe           = rsp_strobe_ff;
   assign rsp_entry_valid      = rsp_valid_ff;
   assign rsp_out_address      = rsp_entry_ff.addr;
   assign rsp_out_strength     = rsp_entry_ff.strength;
   assign rsp_out_channel      = rsp_entry_ff.channel;
   assign rsp_out_name_matches = rsp_entry_ff.match;
   assign rsp_last_entry       = rsp_last_ff;

endmodule

[rtl/core/smbst_check.sv]
// ----------------------------------------------------------------------------
// smbst_check
// Port-level checker for the scan table, bound to the top level.
// ----------------------------------------------------------------------------
`include "scan_merge_best_signal_table_defines.svh"

module smbst_check import smbst_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic [1:0]              req_command,
   input logic [ADDR_W-1:0]       req_station_address,
   input logic signed [STR_W-1:0] req_signal_strength,
   input logic [CHAN_W-1:0]       req_radio_channel,
   input logic                    req_name_matches,
   input logic                    rsp_strobe,
   input logic                    rsp_entry_valid,
   input logic [ADDR_W-1:0]       rsp_out_address,
   input logic signed [STR_W-1:0] rsp_out_strength,
   input logic [CHAN_W-1:0]       rsp_out_channel,
   input logic                    rsp_out_name_matches,
   input logic                    rsp_last_entry
);

   // empty-table result is a run of one
   `SMBST_ASSERT_SAME(a_invalid_is_last, clock, reset, rsp_strobe && !rsp_entry_valid, rsp_last_entry && (rsp_out_address == '0))

   // back-to-back results of one run never rise in strength
   `SMBST_ASSERT_SAME(a_descending, clock, reset, rsp_strobe && $past(rsp_strobe) && $past(rsp_entry_valid) && !$past(rsp_last_entry), rsp_out_strength <= $past(rsp_out_strength))

   // a result only follows an accepted item or ongoing work
   `SMBST_ASSERT_SAME(a_no_spurious, clock, reset, rsp_strobe, $past(busy) || $past(start))

   // insert gives no result and holds the block busy
   `SMBST_ASSERT_NEXT(a_insert_quiet, clock, reset, start && !busy && (req_command == CMD_INSERT), busy && !rsp_strobe)

endmodule

bind scan_merge_best_signal_table smbst_check u_smbst_check (.*);

[tb/scan_merge_best_signal_table_checker.sv]
// ----------------------------------------------------------------------------
// Scan table result checker
// Watches the command and result ports, keeps a shadow of the scan table, and
// compares every strobed result with the oldest predicted one.
// ----------------------------------------------------------------------------
module scan_merge_best_signal_table_checker import smbst_pkg::*; #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    busy,
   input  logic [1:0]              req_command,
   input  logic [ADDR_W-1:0]       req_station_address,
   input  logic signed [STR_W-1:0] req_signal_strength,
   input  logic [CHAN_W-1:0]       req_radio_channel,
   input  logic                    req_name_matches,
   input  logic                    rsp_strobe,
   input  logic                    rsp_entry_valid,
   input  logic [ADDR_W-1:0]       rsp_out_address,
   input  logic signed [STR_W-1:0] rsp_out_strength,
   input  logic [CHAN_W-1:0]       rsp_out_channel,
   input  logic                    rsp_out_name_matches,
   input  logic                    rsp_last_entry,
   output int                      fail_count,
   output int                      pending,
   output int                      checked_count
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                    valid;
      logic [ADDR_W-1:0]       addr;
      logic signed [STR_W-1:0] strength;
      logic [CHAN_W-1:0]       channel;
      logic                    match;
      logic                    last;
   } ranked_entry_type;

   entry_type        shadow_table [TABLE_DEPTH];
   int               shadow_fill = 0;
   ranked_entry_type ranked_due [$];
   int               errors = 0;
   int               results_seen = 0;

   // keep the strongest record per address; new addresses only while room
   task automatic merge_record(input entry_type rec);
      int slot;
      slot = -1;
      for (int i = 0; i < shadow_fill; i++) begin
         if (slot < 0 && shadow_table[i].addr == rec.addr) slot = i;
      end
      if (slot >= 0) begin
         if ($signed(rec.strength) > $signed(shadow_table[slot].strength))
            shadow_table[slot] = rec;
      end else if (shadow_fill < TABLE_DEPTH) begin
         shadow_table[shadow_fill] = rec;
         shadow_fill++;
      end
   endtask

   // stable descending sort by strength, ties keep insertion order
   task automatic rank_entries();
      int               order [TABLE_DEPTH];
      int               j;
      ranked_entry_type r;
      r = '0;
      if (shadow_fill == 0) begin
         r.last = 1'b1;
         ranked_due.push_back(r);
      end else begin
         for (int i = 0; i < shadow_fill; i++) begin
            j = i;
            while (j > 0 && $signed(shadow_table[order[j-1]].strength)
                            < $signed(shadow_table[i].strength)) begin
               order[j] = order[j-1];
               j--;
            end
            order[j] = i;
         end
         for (int i = 0; i < shadow_fill; i++) begin
            r.valid    = 1'b1;
            r.addr     = shadow_table[order[i]].addr;
            r.strength = shadow_table[order[i]].strength;
            r.channel  = shadow_table[order[i]].channel;
            r.match    = shadow_table[order[i]].match;
            r.last     = (i == shadow_fill - 1);
            ranked_due.push_back(r);
         end
      end
   endtask

   always @(posedge clock) begin
      ranked_entry_type want;
      entry_type        rec;
      if (reset) begin
         shadow_fill = 0;
         ranked_due.delete();
      end else begin
         // results first: an item accepted at this edge cannot own this result
         if (rsp_strobe) begin
            results_seen++;
            if (ranked_due.size() == 0) begin
               if (errors < 10)
                  $display("[%0t] unexpected result: valid=%0b addr=%h last=%0b", $time,
                           rsp_entry_valid, rsp_out_address, rsp_last_entry);
               errors++;
            end else begin
               want = ranked_due.pop_front();
               if (rsp_entry_valid !== want.valid || rsp_out_address !== want.addr ||
                   rsp_out_strength !== want.strength || rsp_out_channel !== want.channel ||
                   rsp_out_name_matches !== want.match || rsp_last_entry !== want.last) begin
                  if (errors < 10) begin
                     $display("[%0t] result mismatch: expected valid=%0b addr=%h str=%0d ch=%0d match=%0b last=%0b",
                              $time, want.valid, want.addr, want.strength, want.channel,
                              want.match, want.last);
                     $display("        got valid=%0b addr=%h str=%0d ch=%0d match=%0b last=%0b",
                              rsp_entry_valid, rsp_out_address, rsp_out_strength,
                              rsp_out_channel, rsp_out_name_matches, rsp_last_entry);
                  end
                  errors++;
               end
            end
         end
         if (start && !busy) begin
            case (req_command)
               CMD_CLEAR: begin
                  shadow_fill = 0;
               end
               CMD_INSERT: begin
                  rec.addr     = req_station_address;
                  rec.strength = req_signal_strength;
                  rec.channel  = req_radio_channel;
                  rec.match    = req_name_matches;
                  merge_record(rec);
               end
               CMD_FINISH: begin
                  rank_entries();
               end
               default: ;
            endcase
         end
      end
      fail_count    <= errors;
      pending       <= ranked_due.size();
      checked_count <= results_seen;
   end

endmodule

[tb/tb_scan_merge_best_signal_table.sv]
// ----------------------------------------------------------------------------
// Scan table testbench
// Directed corner items, then random scan sessions (clear, inserts with
// repeated addresses, finish) under several idle settings; a checker module
// predicts and compares every sorted result.
// ----------------------------------------------------------------------------
module tb_scan_merge_best_signal_table import smbst_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int         TABLE_DEPTH = 32;
   localparam int         RANDOM_ITEMS = 250;
   localparam int         SETTLE_CYCLES = TABLE_DEPTH + 8;  // longest insert walk + margin
   localparam logic [1:0] CMD_UNUSED = 2'd3;                 // reserved code, no effect

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [1:0]              req_command = CMD_CLEAR;
   logic [ADDR_W-1:0]       req_station_address = '0;
   logic signed [STR_W-1:0] req_signal_strength = '0;
   logic [CHAN_W-1:0]       req_radio_channel = '0;
   logic                    req_name_matches = 1'b0;
   logic                    rsp_strobe;
   logic                    rsp_entry_valid;
   logic [ADDR_W-1:0]       rsp_out_address;
   logic signed [STR_W-1:0] rsp_out_strength;
   logic [CHAN_W-1:0]       rsp_out_channel;
   logic                    rsp_out_name_matches;
   logic                    rsp_last_entry;

   int fail_count;
   int pending;
   int checked_count;

   // stimulus bookkeeping
   int idle_pct = 0;          // chance in percent that the sender idles before an item
   int items_sent = 0;        // accepted items, reserved command code excluded
   int finishes_sent = 0;
   int full_fills = 0;        // sessions that push the table past its depth

   // per phase sender idle: none, sender idle, receiver stall (cannot happen
   // here, so the sender runs flat out again), both sides idle
   int phase_idle [4] = '{0, 69, 0, 21};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   scan_merge_best_signal_table #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_command         (req_command),
      .req_station_address (req_station_address),
      .req_signal_strength (req_signal_strength),
      .req_radio_channel   (req_radio_channel),
      .req_name_matches    (req_name_matches),
      .rsp_strobe          (rsp_strobe),
      .rsp_entry_valid     (rsp_entry_valid),
      .rsp_out_address     (rsp_out_address),
      .rsp_out_strength    (rsp_out_strength),
      .rsp_out_channel     (rsp_out_channel),
      .rsp_out_name_matches(rsp_out_name_matches),
      .rsp_last_entry      (rsp_last_entry)
   );

   scan_merge_best_signal_table_checker #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_command         (req_command),
      .req_station_address (req_station_address),
      .req_signal_strength (req_signal_strength),
      .req_radio_channel   (req_radio_channel),
      .req_name_matches    (req_name_matches),
      .rsp_strobe          (rsp_strobe),
      .rsp_entry_valid     (rsp_entry_valid),
      .rsp_out_address     (rsp_out_address),
      .rsp_out_strength    (rsp_out_strength),
      .rsp_out_channel     (rsp_out_channel),
      .rsp_out_name_matches(rsp_out_name_matches),
      .rsp_last_entry      (rsp_last_entry),
      .fail_count          (fail_count),
      .pending             (pending),
      .checked_count       (checked_count)
   );

   // full 48-bit random address, every bit free to toggle
   function automatic logic [ADDR_W-1:0] rand_addr();
      logic [ADDR_W-1:0] a;
      a[47:32] = 16'($urandom_range(16'hFFFF));
      a[31:0]  = $urandom;
      return a;
   endfunction

   // mostly uniform strengths; half from a tiny set so ties and repeats
   // with equal strength come up often
   function automatic logic signed [STR_W-1:0] rand_strength();
      logic signed [STR_W-1:0] s;
      case ($urandom_range(5))
         0:       s = -8'sd128;
         1:       s = 8'sd127;
         2:       s = -8'sd60;
         default: s = STR_W'($urandom_range(255));
      endcase
      return s;
   endfunction

   function automatic logic [CHAN_W-1:0] rand_chan();
      return CHAN_W'($urandom_range(255));
   endfunction

   function automatic logic rand_bit();
      return 1'($urandom_range(1));
   endfunction

   // Drive one item at the falling edge, hold it until the block takes it.
   // An optional idle gap drops start first; the gap starts right after the
   // previous acceptance, so it overlaps whatever the block is busy with.
   task automatic send_item(input logic [1:0] cmd, input logic [ADDR_W-1:0] addr,
                            input logic signed [STR_W-1:0] strength,
                            input logic [CHAN_W-1:0] chan, input logic match);
      int gap;
      gap = 0;
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) gap = $urandom_range(12, 1);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start               <= 1'b1;
      req_command         <= cmd;
      req_station_address <= addr;
      req_signal_strength <= strength;
      req_radio_channel   <= chan;
      req_name_matches    <= match;
      do @(posedge clock); while (busy);
      if (cmd != CMD_UNUSED) items_sent++;
      if (cmd == CMD_FINISH) finishes_sent++;
   endtask

   // finish with don't-care fields randomized
   task automatic send_finish();
      send_item(CMD_FINISH, rand_addr(), rand_strength(), rand_chan(), rand_bit());
   endtask

   // stop sending until every predicted result is out and the block is idle
   task automatic drain_all();
      @(negedge clock);
      start <= 1'b0;
      do @(posedge clock); while (pending != 0 || busy);
   endtask

   // One scan session: usually a clear, a burst of inserts over an address
   // pool (small pools give many repeats), then a finish. Some sessions use
   // distinct addresses past the table depth so the tail is dropped.
   task automatic run_session();
      logic [ADDR_W-1:0] pool [$];
      logic [ADDR_W-1:0] a;
      int                n_ins;
      int                pool_size;
      int                roll;
      bit                full_fill;
      full_fill = ($urandom_range(7) == 0);
      n_ins     = full_fill ? TABLE_DEPTH + $urandom_range(6, 1) : $urandom_range(12, 1);
      pool_size = full_fill ? n_ins : $urandom_range(n_ins, 1);
      for (int i = 0; i < pool_size; i++) pool.push_back(rand_addr());

      if (full_fill || $urandom_range(4) != 0)
         send_item(CMD_CLEAR, rand_addr(), rand_strength(), rand_chan(), rand_bit());

      for (int i = 0; i < n_ins; i++) begin
         roll = $urandom_range(99);
         if (!full_fill && roll < 6) begin
            // reserved code as noise
            send_item(CMD_UNUSED, rand_addr(), rand_strength(), rand_chan(), rand_bit());
         end else if (!full_fill && roll < 9) begin
            // stray clear in the middle of a session
            send_item(CMD_CLEAR, rand_addr(), rand_strength(), rand_chan(), rand_bit());
         end else begin
            a = full_fill ? pool[i] : pool[$urandom_range(pool_size - 1)];
            send_item(CMD_INSERT, a, rand_strength(), rand_chan(), rand_bit());
         end
      end

      // on a full table, repeats of stored addresses still update in place
      if (full_fill) begin
         full_fills++;
         repeat (2)
            send_item(CMD_INSERT, pool[$urandom_range(TABLE_DEPTH - 1)], rand_strength(),
                      rand_chan(), rand_bit());
      end

      send_finish();
      // sometimes keep adding after a finish to show the table survives it
      if ($urandom_range(3) == 0) begin
         send_item(CMD_INSERT, pool[$urandom_range(pool_size - 1)], rand_strength(),
                   rand_chan(), rand_bit());
         send_finish();
      end
   endtask

   initial begin
      int base;

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // --- directed corners ---
      send_finish();                                                   // empty table
      send_item(CMD_INSERT, 48'h0, -8'sd128, 8'd0, 1'b0);              // all-low fields
      send_item(CMD_INSERT, 48'hFFFF_FFFF_FFFF, 8'sd127, 8'd255, 1'b1); // all-high fields
      send_item(CMD_INSERT, 48'hFFFF_FFFF_FFFF, 8'sd127, 8'd7, 1'b0);  // equal repeat at max
      send_item(CMD_INSERT, 48'h0, -8'sd128, 8'd9, 1'b1);              // equal repeat at min
      send_item(CMD_INSERT, 48'h0, -8'sd127, 8'd200, 1'b1);            // stronger: replace
      send_item(CMD_INSERT, 48'h0, -8'sd128, 8'd3, 1'b0);              // weaker: keep
      send_item(CMD_INSERT, 48'hA5A5_5A5A_0F0F, 8'sd0, 8'd36, 1'b1);   // three-way tie
      send_item(CMD_INSERT, 48'h5A5A_A5A5_F0F0, 8'sd0, 8'd40, 1'b0);
      send_item(CMD_INSERT, 48'h1234_5678_9ABC, 8'sd0, 8'd44, 1'b1);
      send_item(CMD_UNUSED, 48'hFFFF_FFFF_FFFF, -8'sd1, 8'd255, 1'b1); // reserved code
      send_finish();
      send_finish();                                                   // table kept
      send_item(CMD_CLEAR, 48'hFFFF_FFFF_FFFF, -8'sd1, 8'd255, 1'b1);
      send_finish();                                                   // empty after clear
      send_item(CMD_INSERT, 48'hFFFF_FFFF_FFFF, -8'sd1, 8'd165, 1'b0);
      send_item(CMD_INSERT, 48'h0000_0000_0001, -8'sd1, 8'd90, 1'b1);  // tie at -1
      send_finish();
      send_item(CMD_CLEAR, 48'h0, 8'sd0, 8'd0, 1'b0);
      drain_all();

      // --- random sessions over four idle settings ---
      base = items_sent;
      for (int phase = 0; phase < 4; phase++) begin
         idle_pct = phase_idle[phase];
         while (items_sent - base < RANDOM_ITEMS * (phase + 1) / 4) run_session();
         // hold off until all predicted results are out before the next phase
         drain_all();
      end

      // late or extra results would show up within this window
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d items incl. %0d finishes and %0d table-overflow sessions;",
               items_sent, finishes_sent, full_fills);
      $display("%0d results checked across four idle settings, %0d mismatches.",
               checked_count, fail_count);
      if (fail_count == 0 && pending == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // every item, a full-table sort after the longest idle gap too, ends far
   // within this limit
   initial begin
      #20ms;
      $display("Timeout with %0d results outstanding", pending);
      $display("FAILED: results differ");
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/smbst_pkg.sv
rtl/core/smbst_cmp.sv
rtl/core/smbst_entry_ram.sv
rtl/core/scan_merge_best_signal_table.sv
rtl/core/smbst_check.sv
tb/scan_merge_best_signal_table_checker.sv
tb/tb_scan_merge_best_signal_table.sv
